FILE: hdl/bdqs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdqs_pkg: shared types for the bounded deque with search
// Opcodes, controller states and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdqs_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_SRCH = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture opcode and value
    logic srch_start; // set up scan at the front entry
    logic srch_step;  // scan step: issue a read, compare the last one
    logic commit;     // apply the operation and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;  // latched opcode is a search
    logic cnt_zero;   // queue holds no entries
    logic srch_done;  // match seen or last entry compared
  } sts_t;

endpackage : bdqs_pkg
`default_nettype wire

FILE: hdl/bdqs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdqs_ctrl: sequencing controller
// Accepts one item at a time, steps the datapath through execute / scan,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module bdqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output bdqs_pkg::cmd_t cmd,
  input  bdqs_pkg::sts_t sts
);
  import bdqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   slot_free;

  assign slot_free  = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_tready   = 1'b0;
    out_vld_nxt = out_vld_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_search && !sts.cnt_zero) begin
          cmd.srch_start = 1'b1;
          state_nxt      = ST_SRCH;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SRCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.commit  = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_vld_r || out_tready))
    else $error("result register overwritten");

endmodule : bdqs_ctrl
`default_nettype wire

FILE: hdl/bdqs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdqs_dp: deque datapath
// Ring-buffer entry memory, head and count registers, the scan pointer with
// its registered read and compare, and the result register.
// ----------------------------------------------------------------------------
module bdqs_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bdqs_pkg::OP_W-1:0]         op_in,
  input  logic signed [bdqs_pkg::DATA_W-1:0] value_in,
  input  bdqs_pkg::cmd_t                    cmd,
  output bdqs_pkg::sts_t                    sts,
  output logic                              res_ok,
  output logic [bdqs_pkg::CNT_OUT_W-1:0]    res_count,
  output logic                              res_empty
);
  import bdqs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_S   = (CW+1)'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];

  op_t                      op_r;
  logic signed [DATA_W-1:0] val_r;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;

  // scan
  logic [CW-1:0]            iss_idx_r;
  logic [AW-1:0]            rd_ptr_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     rd_vld_r;
  logic                     rd_last_r;
  logic                     found_r;
  logic                     issue;
  logic                     match;

  // commit
  logic                     ok_nxt;
  logic                     wr_en;
  logic [AW-1:0]            wr_ptr;
  logic [AW-1:0]            head_dec, head_inc;
  logic [CW:0]              tail_sum;
  logic [AW-1:0]            tail_slot;

  // result
  logic                     res_ok_r;
  logic [CW-1:0]            res_cnt_r;
  logic [CW+CNT_OUT_W-1:0]  res_cnt_ext;

  assign head_dec  = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_sum  = (CW+1)'(head_r) + (CW+1)'(cnt_r);
  assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

  assign issue = cmd.srch_step && (iss_idx_r < cnt_r);
  assign match = rd_vld_r && (rd_data_r == val_r);

  assign sts.is_search = (op_r == OP_SEARCH);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.srch_done = rd_vld_r && (match || rd_last_r);

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    ok_nxt   = 1'b0;
    wr_en    = 1'b0;
    wr_ptr   = head_dec;
    case (op_r)
      OP_PUSH_FRONT: begin
        if (cnt_r != FULL_CNT) begin
          head_nxt = head_dec;
          cnt_nxt  = cnt_r + 1'b1;
          wr_en    = 1'b1;
          ok_nxt   = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        wr_ptr = tail_slot;
        if (cnt_r != FULL_CNT) begin
          cnt_nxt = cnt_r + 1'b1;
          wr_en   = 1'b1;
          ok_nxt  = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (cnt_r != '0) begin
          head_nxt = head_inc;
          cnt_nxt  = cnt_r - 1'b1;
          ok_nxt   = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          ok_nxt  = 1'b1;
        end
      end
      OP_SEARCH: begin
        ok_nxt = found_r;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        head_r <= head_nxt;
        cnt_r  <= cnt_nxt;
      end
      rd_vld_r <= issue;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(op_in);
      val_r <= value_in;
    end
    if (cmd.latch || cmd.srch_start) begin
      found_r <= 1'b0;
    end else if (cmd.srch_step && match) begin
      found_r <= 1'b1;
    end
    if (cmd.srch_start) begin
      iss_idx_r <= '0;
      rd_ptr_r  <= head_r;
    end else if (issue) begin
      iss_idx_r <= iss_idx_r + 1'b1;
      rd_ptr_r  <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      rd_last_r <= (iss_idx_r == cnt_r - 1'b1);
    end
    if (cmd.commit) begin
      res_ok_r  <= ok_nxt;
      res_cnt_r <= cnt_nxt;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_ptr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign res_cnt_ext = (CW+CNT_OUT_W)'(res_cnt_r);
  assign res_ok      = res_ok_r;
  assign res_count   = res_cnt_ext[CNT_OUT_W-1:0];
  assign res_empty   = (res_cnt_r == '0);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_SLOT)
    else $error("head pointer outside ring");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_step |-> (iss_idx_r <= cnt_r))
    else $error("scan ran past the live entries");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cnt_r == FULL_CNT &&
     (op_r == OP_PUSH_FRONT || op_r == OP_PUSH_BACK)) |=> (cnt_r == FULL_CNT && !res_ok_r))
    else $error("push into full queue changed state");

endmodule : bdqs_dp
`default_nettype wire

FILE: hdl/bounded_deque_with_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core: bounded deque of 32-bit values with search
// Ring-buffer deque with push/pop at either end and a front-to-back search,
// one result per request.
// ----------------------------------------------------------------------------
// One request in flight at a time. From accept to result: push, pop and
// unused opcodes pass through capture, execute and commit; a search scans
// the live entries from the front and stops early on the first match.
// The scan is bound by the single read port of the entry memory, one entry
// per cycle, with the read data registered before the compare. A new item
// is accepted as soon as the previous one has been committed, even while
// its result still waits in the output register. A push into a full queue
// and a pop from an empty one return ok = 0 and change nothing; count is
// the entry count after the request, masked to 5 bits.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core #(
  parameter int unsigned DEPTH = 16 // capacity, 2 .. 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value (signed)
  input  logic [7:0]  in_tuser,   // [2:0] opcode, [7:3] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] ok, [5:1] count, [6] empty_res, [7] zero
);
  import bdqs_pkg::*;

  cmd_t                     cmd;
  sts_t                     sts;
  logic                     res_ok;
  logic [CNT_OUT_W-1:0]     res_count;
  logic                     res_empty;

  // sequencer: handshakes and step commands
  bdqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage, pointers, scan compare and result register
  bdqs_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_in    (in_tuser[OP_W-1:0]),
    .value_in (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .res_ok   (res_ok),
    .res_count(res_count),
    .res_empty(res_empty)
  );

  // result packing, lowest field first, padded to a byte
  assign out_tdata = {1'b0, res_empty, res_count, res_ok};

  // the only path into the scan is from execute, and only with entries
  a_srch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_start |-> (sts.is_search && !sts.cnt_zero))
    else $error("search started on empty queue");

endmodule : bounded_deque_with_search_core
`default_nettype wire
